FILE: sv/cpa_pkg.sv
`timescale 1ns / 1ps

package cpa_pkg;

    localparam int unsigned ADDR_W  = 56;
    localparam int unsigned COUNT_W = 11;
    localparam int unsigned STAT_W  = 2;

    localparam logic [1:0] FLAGS_EMPTY   = 2'b00;
    localparam logic [1:0] FLAGS_TAKEN   = 2'b01;
    localparam logic [1:0] FLAGS_RUN_END = 2'b11;

    localparam int unsigned FLAG_TAKEN_BIT = 0;
    localparam int unsigned FLAG_LAST_BIT  = 1;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADFREE = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_FCHK,
        S_WALK,
        S_DONE
    } t_state;

endpackage

FILE: sv/contiguous_page_allocator_core.sv
`timescale 1ns / 1ps

// First-fit contiguous page allocator. Page descriptors (taken, last-of-run) live in one
// memory with one read and one write per cycle, and each allocate scan and each free walk
// goes through it one page per cycle. After reset the block clears every descriptor with
// o_in_ready low; configuration writes are taken during that time. An allocate scans from
// page 0 for the first free run of page_count pages and then marks it, or scans the whole
// pool when no run fits; an out-of-range count skips the scan. A free clears pages from
// the freed page up to the last page of its run, stopping at a page that is not taken.
// One item is worked on at a time; the next item is taken while a result still waits in
// the output register.
module contiguous_page_allocator_core
    import cpa_pkg::*;
#(
    parameter int unsigned POOL_PAGES = 1024,
    parameter int unsigned PAGE_SHIFT = 12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [ADDR_W-1:0]   i_cfg_alloc_base,

    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_req_type,
    input  logic [COUNT_W-1:0]  i_page_count,
    input  logic [ADDR_W-1:0]   i_free_addr,

    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STAT_W-1:0]   o_status,
    output logic [ADDR_W-1:0]   o_run_addr
);

    localparam int unsigned IW = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
    localparam int unsigned CW = $clog2(POOL_PAGES + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(POOL_PAGES - 1);
    localparam logic [CW-1:0] END_PTR  = CW'(POOL_PAGES);

    t_state r_state, n_state;

    logic [1:0]        r_mem [POOL_PAGES];
    logic [1:0]        r_rdata;
    logic              mem_we;
    logic [IW-1:0]     mem_wa;
    logic [1:0]        mem_wd;
    logic              mem_re;
    logic [IW-1:0]     mem_ra;

    logic [ADDR_W-1:0] r_alloc_base;
    logic [CW-1:0]     r_rd_ptr,  n_rd_ptr;
    logic              r_dv,      n_dv;
    logic [IW-1:0]     r_chk_idx, n_chk_idx;
    logic [CW-1:0]     r_run,     n_run;
    logic [CW-1:0]     r_count,   n_count;
    logic [IW-1:0]     r_wr_ptr,  n_wr_ptr;
    logic [IW-1:0]     r_end,     n_end;
    logic [IW-1:0]     r_start,   n_start;
    logic [ADDR_W-1:0] r_diff,    n_diff;
    logic [STAT_W-1:0] r_res_status, n_res_status;
    logic [ADDR_W-1:0] r_res_addr,   n_res_addr;

    logic              r_out_valid;
    logic [STAT_W-1:0] r_status;
    logic [ADDR_W-1:0] r_run_addr;

    logic              in_acc;
    logic              count_bad;
    logic              issue;
    logic              chk_taken;
    logic              chk_last;
    logic              chk_at_end;
    logic [CW-1:0]     run_next;
    logic              found;
    logic [IW-1:0]     start_calc;
    logic              out_free;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_run_addr  = r_run_addr;

    assign count_bad  = (i_page_count == '0) ||
                        ({21'd0, i_page_count} > 32'(POOL_PAGES));
    assign issue      = (r_rd_ptr != END_PTR);
    assign chk_taken  = r_rdata[FLAG_TAKEN_BIT];
    assign chk_last   = r_rdata[FLAG_LAST_BIT];
    assign chk_at_end = (r_chk_idx == LAST_IDX);
    assign run_next   = chk_taken ? '0 : (r_run + 1'b1);
    assign found      = r_dv && !chk_taken && (run_next == r_count);
    assign start_calc = IW'(CW'(r_chk_idx) + 1'b1 - r_count);

    // descriptor memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_ra];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_wr_ptr == LAST_IDX) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_acc) begin
                    if (i_req_type == REQ_FREE) n_state = S_FCHK;
                    else if (count_bad)         n_state = S_DONE;
                    else                        n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (found)                    n_state = S_MARK;
                else if (r_dv && chk_at_end)  n_state = S_DONE;
            end
            S_MARK: begin
                if (r_wr_ptr == r_end) n_state = S_DONE;
            end
            S_FCHK: begin
                if (r_diff >= ADDR_W'(POOL_PAGES)) n_state = S_DONE;
                else                               n_state = S_WALK;
            end
            S_WALK: begin
                if (r_dv && (!chk_taken || chk_last || chk_at_end)) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_rd_ptr     = r_rd_ptr;
        n_dv         = 1'b0;
        n_chk_idx    = r_chk_idx;
        n_run        = r_run;
        n_count      = r_count;
        n_wr_ptr     = r_wr_ptr;
        n_end        = r_end;
        n_start      = r_start;
        n_diff       = r_diff;
        n_res_status = r_res_status;
        n_res_addr   = r_res_addr;
        mem_we       = 1'b0;
        mem_wa       = r_wr_ptr;
        mem_wd       = FLAGS_EMPTY;
        mem_re       = 1'b0;
        mem_ra       = r_rd_ptr[IW-1:0];
        unique case (r_state)
            S_CLEAR: begin
                mem_we   = 1'b1;
                n_wr_ptr = r_wr_ptr + 1'b1;
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_count      = CW'(i_page_count);
                    n_run        = '0;
                    n_rd_ptr     = '0;
                    n_diff       = (i_free_addr - r_alloc_base) >> PAGE_SHIFT;
                    n_res_status = ST_NOSPACE;
                    n_res_addr   = '0;
                end
            end
            S_SCAN: begin
                mem_re    = issue;
                n_dv      = issue;
                n_chk_idx = r_rd_ptr[IW-1:0];
                if (issue) n_rd_ptr = r_rd_ptr + 1'b1;
                if (r_dv) begin
                    n_run = run_next;
                    if (found) begin
                        n_start  = start_calc;
                        n_wr_ptr = start_calc;
                        n_end    = r_chk_idx;
                    end
                end
            end
            S_MARK: begin
                mem_we   = 1'b1;
                mem_wd   = (r_wr_ptr == r_end) ? FLAGS_RUN_END : FLAGS_TAKEN;
                n_wr_ptr = r_wr_ptr + 1'b1;
                if (r_wr_ptr == r_end) begin
                    n_res_status = ST_OK;
                    n_res_addr   = r_alloc_base + (ADDR_W'(r_start) << PAGE_SHIFT);
                end
            end
            S_FCHK: begin
                n_rd_ptr     = CW'(r_diff[IW-1:0]);
                n_res_status = ST_BADFREE;
                n_res_addr   = '0;
            end
            S_WALK: begin
                mem_re    = issue;
                n_dv      = issue;
                n_chk_idx = r_rd_ptr[IW-1:0];
                if (issue) n_rd_ptr = r_rd_ptr + 1'b1;
                if (r_dv && chk_taken) begin
                    mem_we = 1'b1;
                    mem_wa = r_chk_idx;
                    mem_wd = FLAGS_EMPTY;
                    if (chk_last) n_res_status = ST_OK;
                end
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_alloc_base <= '0;
            r_rd_ptr     <= '0;
            r_dv         <= 1'b0;
            r_run        <= '0;
            r_count      <= '0;
            r_wr_ptr     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_ptr <= n_rd_ptr;
            r_dv     <= n_dv;
            r_run    <= n_run;
            r_count  <= n_count;
            r_wr_ptr <= n_wr_ptr;
            if (i_cfg_valid) begin
                r_alloc_base <= i_cfg_alloc_base;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_idx    <= n_chk_idx;
        r_end        <= n_end;
        r_start      <= n_start;
        r_diff       <= n_diff;
        r_res_status <= n_res_status;
        r_res_addr   <= n_res_addr;
        if (r_state == S_DONE && out_free) begin
            r_status   <= r_res_status;
            r_run_addr <= r_res_addr;
        end
    end

endmodule

FILE: sim/contiguous_page_allocator_core_tb.sv
`timescale 1ns / 1ps

module contiguous_page_allocator_core_tb;
    import cpa_pkg::*;

    localparam int unsigned POOL_PAGES  = 1024;
    localparam int unsigned PAGE_SHIFT  = 12;
    localparam logic [ADDR_W-1:0] ADDR_MAX = '1;
    localparam int unsigned CYCLE_LIMIT = 8_000_000;
    localparam int unsigned TAIL_CYCLES = 1100;

    // Page descriptor pool as the block should see it, plus results still owed.
    class page_pool_tracker;
        logic [1:0]        page_flags [POOL_PAGES];
        logic [ADDR_W-1:0] base;
        logic [STAT_W-1:0] status_due_q [$];
        logic [ADDR_W-1:0] addr_due_q [$];
        logic [STAT_W-1:0] last_status;
        logic [ADDR_W-1:0] last_addr;
        int unsigned       errors;

        function new();
            foreach (page_flags[i]) page_flags[i] = FLAGS_EMPTY;
            base   = '0;
            errors = 0;
        endfunction

        function bit page_taken(int unsigned idx);
            return page_flags[idx][FLAG_TAKEN_BIT];
        endfunction

        function int unsigned pending();
            return status_due_q.size();
        endfunction

        // first fit over every start, the last possible one included
        function logic [STAT_W-1:0] claim_run(logic [COUNT_W-1:0] cnt,
                                              output logic [ADDR_W-1:0] addr);
            int unsigned run;
            int unsigned start;
            run  = 0;
            addr = '0;
            if (cnt == 0 || cnt > POOL_PAGES) return ST_NOSPACE;
            for (int unsigned p = 0; p < POOL_PAGES; p++) begin
                if (page_flags[p][FLAG_TAKEN_BIT]) begin
                    run = 0;
                end else begin
                    run++;
                    if (run == cnt) begin
                        start = p + 1 - cnt;
                        for (int unsigned k = start; k < p; k++) page_flags[k] = FLAGS_TAKEN;
                        page_flags[p] = FLAGS_RUN_END;
                        addr = base + (ADDR_W'(start) << PAGE_SHIFT);
                        return ST_OK;
                    end
                end
            end
            return ST_NOSPACE;
        endfunction

        // pages cleared before a bad page stay cleared
        function logic [STAT_W-1:0] release_run(logic [ADDR_W-1:0] faddr);
            logic [ADDR_W-1:0] idx;
            logic [1:0]        f;
            idx = (faddr - base) >> PAGE_SHIFT;
            if (idx >= POOL_PAGES) return ST_BADFREE;
            for (int unsigned p = int'(idx); p < POOL_PAGES; p++) begin
                f = page_flags[p];
                if (!f[FLAG_TAKEN_BIT]) return ST_BADFREE;
                page_flags[p] = FLAGS_EMPTY;
                if (f[FLAG_LAST_BIT]) return ST_OK;
            end
            return ST_BADFREE;
        endfunction

        function void take_request(logic req, logic [COUNT_W-1:0] cnt,
                                   logic [ADDR_W-1:0] faddr);
            last_addr = '0;
            if (req == REQ_ALLOC) last_status = claim_run(cnt, last_addr);
            else last_status = release_run(faddr);
            status_due_q.push_back(last_status);
            addr_due_q.push_back(last_addr);
        endfunction

        function void check_result(logic [STAT_W-1:0] st, logic [ADDR_W-1:0] addr);
            logic [STAT_W-1:0] exp_st;
            logic [ADDR_W-1:0] exp_addr;
            if (status_due_q.size() == 0) begin
                $error("result with none expected: status %0d run_addr %h", st, addr);
                errors++;
                return;
            end
            exp_st   = status_due_q.pop_front();
            exp_addr = addr_due_q.pop_front();
            if (st !== exp_st) begin
                $error("status: expected %0d, got %0d", exp_st, st);
                errors++;
            end
            if (addr !== exp_addr) begin
                $error("run_addr: expected %h, got %h", exp_addr, addr);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [ADDR_W-1:0]  i_cfg_alloc_base = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_req_type = REQ_ALLOC;
    logic [COUNT_W-1:0] i_page_count = '0;
    logic [ADDR_W-1:0]  i_free_addr = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [STAT_W-1:0]  o_status;
    logic [ADDR_W-1:0]  o_run_addr;

    page_pool_tracker tracker = new();
    int               live_pages [$];
    int unsigned      send_idle_pct = 0;
    int unsigned      recv_idle_pct = 0;
    int unsigned      cycle_count = 0;

    contiguous_page_allocator_core #(
        .POOL_PAGES (POOL_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_alloc_base (i_cfg_alloc_base),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_req_type       (i_req_type),
        .i_page_count     (i_page_count),
        .i_free_addr      (i_free_addr),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_run_addr       (o_run_addr)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) tracker.check_result(o_status, o_run_addr);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("contiguous_page_allocator_core_tb failed");
            $finish;
        end
    end

    function logic [ADDR_W-1:0] rand_addr();
        return ADDR_W'({$urandom(), $urandom()});
    endfunction

    function logic [ADDR_W-1:0] page_addr(int unsigned idx);
        return tracker.base + (ADDR_W'(idx) << PAGE_SHIFT);
    endfunction

    function int unsigned pick_count();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(16, 1);
        if (r < 92) return $urandom_range(128, 17);
        return $urandom_range(POOL_PAGES, 129);
    endfunction

    task automatic send_request(logic req, logic [COUNT_W-1:0] cnt, logic [ADDR_W-1:0] faddr);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= req;
        i_page_count <= cnt;
        i_free_addr  <= faddr;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.take_request(req, cnt, faddr);
        if (req == REQ_ALLOC && tracker.last_status == ST_OK) begin
            live_pages.push_back(int'((tracker.last_addr - tracker.base) >> PAGE_SHIFT));
        end else if (req == REQ_FREE) begin
            for (int i = live_pages.size() - 1; i >= 0; i--) begin
                if (!tracker.page_taken(live_pages[i])) live_pages.delete(i);
            end
        end
    endtask

    task automatic alloc_pages(int unsigned cnt);
        send_request(REQ_ALLOC, COUNT_W'(cnt), rand_addr());
    endtask

    task automatic free_at(logic [ADDR_W-1:0] faddr);
        send_request(REQ_FREE, COUNT_W'($urandom()), faddr);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0);
    endtask

    task automatic write_base(logic [ADDR_W-1:0] value);
        i_cfg_valid      <= 1'b1;
        i_cfg_alloc_base <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid  <= 1'b0;
        tracker.base = value;
    endtask

    // mostly alloc/free of live runs; some stray frees into the pool and raw noise
    task automatic run_random(int unsigned n_items, int unsigned send_pct,
                              int unsigned recv_pct, logic [ADDR_W-1:0] new_base);
        int unsigned r;
        int          pick;
        drain();
        write_base(new_base);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (n_items) begin
            r = $urandom_range(99);
            if ($urandom_range(199) == 0) drain();
            if (r < 5) begin
                send_request(1'($urandom_range(1)), COUNT_W'($urandom()), rand_addr());
            end else if (r < 12) begin
                free_at(page_addr($urandom_range(1) ? $urandom_range(63)
                                                    : $urandom_range(POOL_PAGES - 1))
                        + ADDR_W'($urandom_range(4095)));
            end else if (live_pages.size() == 0 || (r < 56 && live_pages.size() < 20)) begin
                alloc_pages(pick_count());
            end else begin
                pick = $urandom_range(live_pages.size() - 1);
                free_at(page_addr(live_pages[pick]));
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_base('0);

        alloc_pages(0);
        alloc_pages(POOL_PAGES + 1);
        alloc_pages(2047);
        alloc_pages(POOL_PAGES);
        alloc_pages(1);
        free_at(page_addr(0));
        free_at(page_addr(0));
        alloc_pages(1);
        alloc_pages(3);
        alloc_pages(2);
        free_at(page_addr(2));
        free_at(page_addr(1));
        free_at(page_addr(4) + ADDR_W'(12'hfff));
        free_at(ADDR_MAX);
        free_at(page_addr(POOL_PAGES - 1));
        alloc_pages(POOL_PAGES - 1);
        free_at(page_addr(1));
        free_at(page_addr(0));

        // base at the top of the space: addresses wrap
        drain();
        write_base(ADDR_MAX);
        alloc_pages(1);
        alloc_pages(2);
        free_at(page_addr(1));
        free_at(page_addr(0));
        free_at('0);
        free_at(ADDR_MAX - ADDR_W'(1));

        run_random(545, 17, 88, rand_addr() & ~((ADDR_W'(1) << PAGE_SHIFT) - ADDR_W'(1)));
        run_random(545, 88, 17, ADDR_MAX);
        run_random(545, 0, 0, '0);

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("contiguous_page_allocator_core_tb passed");
        end else begin
            $display("contiguous_page_allocator_core_tb failed");
        end
        $finish;
    end

endmodule
